/* sv/gopd_pkg.sv */
// ----------------------------------------------------------------------------
// gopd_pkg
// Shared types, constants and helpers for the glyph outline point decoder:
// item layouts on both channels, the command queue entry and flag packing.
// ----------------------------------------------------------------------------
package gopd_pkg;

   // outline capacity
   localparam int MaxPoints = 32;
   localparam int PtIdxW    = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
   localparam int PtCntW    = $clog2(MaxPoints + 1);

   // command queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // opcodes
   localparam logic OpBegin = 1'b0;
   localparam logic OpData  = 1'b1;

   // result codes
   localparam logic StatusCoord = 1'b0;
   localparam logic StatusClip  = 1'b1;
   localparam logic AxisX       = 1'b0;
   localparam logic AxisY       = 1'b1;

   // raw flag byte bit that opens a repeat run
   localparam int FlagRepeatBit = 3;

   typedef struct packed {
      logic       opcode;
      logic [5:0] point_count;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic               status;
      logic               axis;
      logic [4:0]         point_index;
      logic signed [15:0] coord_value;
      logic               anchor;
      logic               last;
   } rsp_item_type;

   // packed flag as kept in the flag store
   typedef struct packed {
      logic y_same;
      logic x_same;
      logic y_short;
      logic x_short;
      logic on;
   } flag_type;

   // classified command
   typedef struct packed {
      logic              is_begin;
      logic [PtCntW-1:0] total;
      logic [7:0]        data;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } queue_wr_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_rd_type;

   // point count of zero means one, counts above capacity are capped
   function automatic logic [PtCntW-1:0] clamp_count(input logic [5:0] c);
      int n;
      n = int'(c);
      if (n == 0) n = 1;
      if (n > MaxPoints) n = MaxPoints;
      return PtCntW'(n);
   endfunction

   // keep on-curve, short and same bits of a raw flag byte
   function automatic flag_type pack_flag(input logic [7:0] b);
      flag_type f;
      f.on      = b[0];
      f.x_short = b[1];
      f.y_short = b[2];
      f.x_same  = b[4];
      f.y_same  = b[5];
      return f;
   endfunction

endpackage

/* sv/gopd_front.sv */
// ----------------------------------------------------------------------------
// gopd_front
// Input side: takes items from the request channel, classifies them into
// begin or data commands, clamps the point count and pushes the queue.
// ----------------------------------------------------------------------------
module gopd_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gopd_pkg::req_item_type req_item,
   input  logic                   queue_full,
   output gopd_pkg::queue_wr_type queue_wr
);
   import gopd_pkg::*;

   // stall while the queue has no room
   assign req_stall = queue_full;

   // classify and push
   always_comb begin
      queue_wr.push         = req_valid && !queue_full;
      queue_wr.cmd.is_begin = (req_item.opcode == OpBegin);
      queue_wr.cmd.total    = clamp_count(req_item.point_count);
      queue_wr.cmd.data     = req_item.data_byte;
   end

endmodule

/* sv/gopd_queue.sv */
// ----------------------------------------------------------------------------
// gopd_queue
// Short command queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module gopd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  gopd_pkg::queue_wr_type queue_wr,
   output logic                   queue_full,
   input  logic                   queue_pop,
   output gopd_pkg::queue_rd_type queue_rd
);
   import gopd_pkg::*;

   cmd_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign queue_full     = (count_ff == QueueCntW'(QueueDepth));
   assign queue_rd.valid = (count_ff != '0);
   assign queue_rd.cmd   = entries_ff[rd_ptr_ff];

   assign do_push = queue_wr.push && !queue_full;
   assign do_pop  = queue_pop && queue_rd.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= queue_wr.cmd;
      end
   end

endmodule

/* sv/gopd_back.sv */
// ----------------------------------------------------------------------------
// gopd_back
// Execution side: keeps the flag store, expands repeat runs one flag a cycle,
// decodes x then y coordinate bytes, emits zero-byte points one a cycle
// while unstalled and holds each result in the output register till taken.
// ----------------------------------------------------------------------------
module gopd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gopd_pkg::queue_rd_type queue_rd,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gopd_pkg::rsp_item_type rsp_item
);
   import gopd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FLAG   = 5'b00010,
      ST_REPEAT = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_COORD  = 5'b10000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              axis_ff, axis_in;
   logic [PtCntW-1:0] total_ff, total_in;
   logic [PtCntW-1:0] cursor_ff, cursor_in;
   logic [PtCntW-1:0] fill_ff, fill_in;
   flag_type          rep_flag_ff, rep_flag_in;
   logic [15:0]       prev_ff, prev_in;
   logic [7:0]        hold_ff, hold_in;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   flag_type          flag_store_ff [MaxPoints];
   flag_type          flag_store_in;
   logic              flag_store_we;

   flag_type          cur_flag;
   logic              cur_short, cur_same, zero_pt;
   logic              can_emit, at_end, rep_over;
   logic [PtCntW-1:0] cursor_nx, room, rep_cnt;
   logic [7:0]        b;
   logic [15:0]       delta, sum;
   logic              emit_en, do_adv, go_coord;
   rsp_item_type      emit_item;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // current point and its flag
   assign cur_flag  = flag_store_ff[cursor_ff[PtIdxW-1:0]];
   assign cur_short = axis_ff ? cur_flag.y_short : cur_flag.x_short;
   assign cur_same  = axis_ff ? cur_flag.y_same : cur_flag.x_same;
   assign zero_pt   = (phase_ff == ST_COORD) && !cur_short && cur_same;

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign cursor_nx = cursor_ff + 1'b1;
   assign at_end    = (cursor_nx >= total_ff);
   assign b         = queue_rd.cmd.data;

   // repeat run clipping against the points left
   assign room      = total_ff - cursor_ff;
   assign rep_over  = (int'(b) > int'(room));
   assign rep_cnt   = rep_over ? room : PtCntW'(b);

   // coordinate delta: short byte with sign from the same bit, or long word
   always_comb begin
      if (cur_short) begin
         delta = cur_same ? {8'h00, b} : 16'h0000 - {8'h00, b};
      end else begin
         delta = {hold_ff, b};
      end
   end
   assign sum = prev_ff + delta;

   // sequencer
   always_comb begin
      phase_in      = phase_ff;
      axis_in       = axis_ff;
      total_in      = total_ff;
      cursor_in     = cursor_ff;
      fill_in       = fill_ff;
      rep_flag_in   = rep_flag_ff;
      prev_in       = prev_ff;
      hold_in       = hold_ff;
      pending_in    = pending_ff;
      queue_pop     = 1'b0;
      flag_store_we = 1'b0;
      flag_store_in = pack_flag(b);
      emit_en       = 1'b0;
      do_adv        = 1'b0;
      go_coord      = 1'b0;

      emit_item             = '0;
      emit_item.status      = StatusCoord;
      emit_item.axis        = axis_ff;
      emit_item.point_index = 5'(cursor_ff);
      emit_item.coord_value = prev_ff;
      emit_item.anchor      = cur_flag.on;
      emit_item.last        = (axis_ff == AxisY) && at_end;

      if (zero_pt) begin
         // point that takes no byte repeats the previous value
         if (can_emit) begin
            emit_en = 1'b1;
            do_adv  = 1'b1;
         end
      end else if (phase_ff == ST_FILL) begin
         // copy the repeated flag, one point a cycle
         flag_store_we = 1'b1;
         flag_store_in = rep_flag_ff;
         cursor_in     = cursor_nx;
         fill_in       = fill_ff - 1'b1;
         if (fill_ff == PtCntW'(1)) begin
            phase_in = ST_FLAG;
            go_coord = at_end;
         end
      end else if (queue_rd.valid && can_emit) begin
         queue_pop = 1'b1;
         if (queue_rd.cmd.is_begin) begin
            phase_in    = ST_FLAG;
            axis_in     = AxisX;
            total_in    = queue_rd.cmd.total;
            cursor_in   = '0;
            rep_flag_in = '0;
            prev_in     = '0;
            hold_in     = '0;
            pending_in  = 1'b0;
         end else begin
            case (phase_ff)
               ST_FLAG: begin
                  flag_store_we = 1'b1;
                  cursor_in     = cursor_nx;
                  if (b[FlagRepeatBit]) begin
                     rep_flag_in = pack_flag(b);
                     phase_in    = ST_REPEAT;
                  end else begin
                     go_coord = at_end;
                  end
               end
               ST_REPEAT: begin
                  if (rep_over) begin
                     emit_en                = 1'b1;
                     emit_item              = '0;
                     emit_item.status       = StatusClip;
                     emit_item.axis         = AxisX;
                     emit_item.point_index  = 5'(cursor_ff - 1'b1);
                  end
                  if (rep_cnt == '0) begin
                     phase_in = ST_FLAG;
                     go_coord = (cursor_ff >= total_ff);
                  end else begin
                     fill_in  = rep_cnt;
                     phase_in = ST_FILL;
                  end
               end
               ST_COORD: begin
                  if (cur_short || pending_ff) begin
                     emit_en               = 1'b1;
                     emit_item.coord_value = sum;
                     prev_in               = sum;
                     pending_in            = 1'b0;
                     do_adv                = 1'b1;
                  end else begin
                     hold_in    = b;
                     pending_in = 1'b1;
                  end
               end
               default: begin
                  // data while idle is dropped
               end
            endcase
         end
      end

      // step to the next point, x axis rolls over into y
      if (do_adv) begin
         if (at_end) begin
            if (axis_ff == AxisX) begin
               axis_in    = AxisY;
               cursor_in  = '0;
               prev_in    = '0;
               hold_in    = '0;
               pending_in = 1'b0;
            end else begin
               phase_in = ST_IDLE;
            end
         end else begin
            cursor_in = cursor_nx;
         end
      end

      // flags complete, start on x coordinates
      if (go_coord) begin
         phase_in   = ST_COORD;
         axis_in    = AxisX;
         cursor_in  = '0;
         prev_in    = '0;
         hold_in    = '0;
         pending_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = emit_en || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = emit_en ? emit_item : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         axis_ff      <= AxisX;
         total_ff     <= '0;
         cursor_ff    <= '0;
         fill_ff      <= '0;
         rep_flag_ff  <= '0;
         prev_ff      <= '0;
         hold_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         total_ff     <= total_in;
         cursor_ff    <= cursor_in;
         fill_ff      <= fill_in;
         rep_flag_ff  <= rep_flag_in;
         prev_ff      <= prev_in;
         hold_ff      <= hold_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // flag store
   always_ff @(posedge clock) begin
      if (flag_store_we) begin
         flag_store_ff[cursor_ff[PtIdxW-1:0]] <= flag_store_in;
      end
   end

   // checks
   a_coord_cursor: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ST_COORD) |-> (cursor_ff < total_ff))
      else $error("coordinate cursor past point total");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ST_FILL) |-> (fill_ff != '0 && cursor_ff < total_ff))
      else $error("repeat fill outside the glyph");

   a_pending_phase: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (phase_ff == ST_COORD))
      else $error("high byte held outside coordinate decode");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_en && emit_item.last) |=> (phase_ff == ST_IDLE))
      else $error("decoder still busy after final y coordinate");

endmodule

/* sv/glyph_outline_point_decoder_core.sv */
// ----------------------------------------------------------------------------
// glyph_outline_point_decoder_core
// Decodes the flag and coordinate part of a simple glyph outline into one
// absolute coordinate per point and axis.
// ----------------------------------------------------------------------------
// Usage: send a begin item with the point count, then the outline bytes
// starting at the flag array. One rsp item comes out for every x and then
// every y coordinate; a repeat run that overruns the point count is clipped
// and reported by one status item. last marks the final y coordinate.
// Both channels are valid/stall; an item moves when valid is high and stall
// is low.
// Structure: the front pushes a command queue of four entries, the back pops it.
// A request item is written into the queue and popped by the back; any result
// it yields is held in the output register that drives rsp_valid. The back
// takes no byte while it copies the flags of a repeat run or while it emits
// a point that takes no byte.
// With rsp_stall low the block takes one byte per cycle outside those steps.
// Reset clears all control state and empties the queue; the flag store is
// not cleared and only entries written for the current glyph are read.
// While rsp_stall is high the result is held, the back pauses on its next
// result, and req_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module glyph_outline_point_decoder_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gopd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gopd_pkg::rsp_item_type rsp_item
);
   import gopd_pkg::*;

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         queue_pop;

   // classification
   gopd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   // command queue
   gopd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_pop  (queue_pop),
      .queue_rd   (queue_rd)
   );

   // decode and output
   gopd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_rd  (queue_rd),
      .queue_pop (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/glyph_outline_point_decoder_core_tb.sv */
// ----------------------------------------------------------------------------
// glyph_outline_point_decoder_core_tb
// Self-checking bench for the outline point decoder. A directed run covers
// the coordinate extremes, 16-bit wrap, clipped repeat runs, bursts of points
// that take no byte and bytes that arrive while idle. Random glyphs follow:
// most are complete with random flags and coordinates, some are cut short or
// trailed by stray bytes. A scoreboard class decodes every accepted item on
// its own and compares each result field by field. Both sides idle at
// random, and the receiver holds off long enough once to back up the input.
// ----------------------------------------------------------------------------
module glyph_outline_point_decoder_core_tb;
   import gopd_pkg::*;

   localparam int StuckLimit = 4000;
   localparam int SettleCycles = 40;
   localparam int StimItems = 129;

   typedef enum logic [4:0] {
      PhIdle   = 5'b00001,
      PhFlag   = 5'b00010,
      PhRepeat = 5'b00100,
      PhX      = 5'b01000,
      PhY      = 5'b10000
   } decode_phase_type;

   // outline decoder prediction and result checking
   class outline_scoreboard;
      rsp_item_type     coords_due[$];
      flag_type         flag_mem[MaxPoints];
      decode_phase_type phase;
      int unsigned      point_total;
      int unsigned      cursor;
      flag_type         run_flag;
      logic [15:0]      last_coord;
      logic [7:0]       high_hold;
      bit               high_pending;
      int               errors, items, begins, results, clips;

      function new();
         foreach (flag_mem[i]) flag_mem[i] = '0;
         phase        = PhIdle;
         point_total  = 0;
         cursor       = 0;
         run_flag     = '0;
         last_coord   = '0;
         high_hold    = '0;
         high_pending = 0;
         errors       = 0;
         items        = 0;
         begins       = 0;
         results      = 0;
         clips        = 0;
      endfunction

      function void start_axis(decode_phase_type ph);
         phase        = ph;
         cursor       = 0;
         last_coord   = '0;
         high_hold    = '0;
         high_pending = 0;
      endfunction

      function flag_type flag_at_cursor();
         return (cursor < MaxPoints) ? flag_mem[cursor] : flag_type'(0);
      endfunction

      // {short, same} for the axis being decoded
      function bit [1:0] axis_bits();
         flag_type f;
         f = flag_at_cursor();
         return (phase == PhY) ? {f.y_short, f.y_same} : {f.x_short, f.x_same};
      endfunction

      function void put_coord(logic [15:0] c);
         rsp_item_type r;
         flag_type     f;
         f             = flag_at_cursor();
         r.status      = StatusCoord;
         r.axis        = (phase == PhY) ? AxisY : AxisX;
         r.point_index = 5'(cursor);
         r.coord_value = c;
         r.anchor      = f.on;
         r.last        = (phase == PhY) && (cursor + 1 == point_total);
         last_coord    = c;
         coords_due.push_back(r);
      endfunction

      function void next_point();
         cursor++;
         if (cursor >= point_total) begin
            if (phase == PhX) start_axis(PhY);
            else phase = PhIdle;
         end
      endfunction

      // points with a long same coordinate repeat the previous value
      function void free_points();
         while ((phase == PhX || phase == PhY) && axis_bits() == 2'b01) begin
            put_coord(last_coord);
            next_point();
         end
      endfunction

      function void note_item(req_item_type it);
         flag_type     p;
         int unsigned  room;
         int unsigned  cnt;
         logic [15:0]  delta;
         bit [1:0]     sm;
         bit           ready;
         rsp_item_type r;
         items++;
         if (it.opcode == OpBegin) begin
            begins++;
            if (it.point_count == 0) point_total = 1;
            else if (it.point_count > MaxPoints) point_total = MaxPoints;
            else point_total = it.point_count;
            cursor       = 0;
            run_flag     = '0;
            last_coord   = '0;
            high_hold    = '0;
            high_pending = 0;
            phase        = PhFlag;
            return;
         end
         case (phase)
            PhFlag: begin
               p.on      = it.data_byte[0];
               p.x_short = it.data_byte[1];
               p.y_short = it.data_byte[2];
               p.x_same  = it.data_byte[4];
               p.y_same  = it.data_byte[5];
               if (cursor < MaxPoints) flag_mem[cursor] = p;
               cursor++;
               if (it.data_byte[FlagRepeatBit]) begin
                  run_flag = p;
                  phase    = PhRepeat;
               end else if (cursor >= point_total) begin
                  start_axis(PhX);
                  free_points();
               end
            end
            PhRepeat: begin
               room = (point_total > cursor) ? point_total - cursor : 0;
               cnt  = it.data_byte;
               // run past the point count: clip and report the source flag
               if (cnt > room) begin
                  cnt           = room;
                  r             = '0;
                  r.status      = StatusClip;
                  r.axis        = AxisX;
                  r.point_index = 5'(cursor - 1);
                  coords_due.push_back(r);
                  clips++;
               end
               repeat (cnt) begin
                  if (cursor < MaxPoints) flag_mem[cursor] = run_flag;
                  cursor++;
               end
               phase = PhFlag;
               if (cursor >= point_total) begin
                  start_axis(PhX);
                  free_points();
               end
            end
            PhX, PhY: begin
               sm    = axis_bits();
               ready = 1;
               if (sm[1]) begin
                  delta = sm[0] ? 16'(it.data_byte) : 16'(0) - 16'(it.data_byte);
               end else if (!high_pending) begin
                  high_hold    = it.data_byte;
                  high_pending = 1;
                  ready        = 0;
               end else begin
                  delta        = {high_hold, it.data_byte};
                  high_pending = 0;
               end
               if (ready) begin
                  put_coord(last_coord + delta);
                  next_point();
               end
               free_points();
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string what, logic signed [16:0] want,
                                  logic signed [16:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         results++;
         if (coords_due.size() == 0) begin
            errors++;
            $display("%0t: result %h with nothing expected", $time, got);
            return;
         end
         want = coords_due.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("axis", want.axis, got.axis);
         compare_field("point_index", want.point_index, got.point_index);
         compare_field("coord_value", want.coord_value, got.coord_value);
         compare_field("anchor", want.anchor, got.anchor);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   outline_scoreboard sb;
   req_item_type      stim[$];
   int                stuck_cycles = 0;

   always #5 clock = ~clock;

   glyph_outline_point_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // stimulus building
   task automatic push_begin(logic [5:0] n);
      req_item_type it;
      it.opcode      = OpBegin;
      it.point_count = n;
      it.data_byte   = 8'($urandom_range(0, 255));
      stim.push_back(it);
   endtask

   task automatic push_data(logic [7:0] b);
      req_item_type it;
      it.opcode      = OpData;
      it.point_count = 6'($urandom_range(0, 63));
      it.data_byte   = b;
      stim.push_back(it);
   endtask

   // one glyph: begin, flags with repeat runs, then x and y bytes
   task automatic add_glyph();
      int         sel, cnt, total, pts, room, rep, keep;
      logic [7:0] fb;
      logic [7:0] point_flags[$];
      logic [7:0] body[$];
      sel = $urandom_range(0, 15);
      if (sel < 11) cnt = $urandom_range(1, 8);
      else if (sel < 13) cnt = $urandom_range(9, 20);
      else if (sel < 14) cnt = $urandom_range(28, 32);
      else if (sel < 15) cnt = 0;
      else cnt = $urandom_range(33, 63);
      total = (cnt == 0) ? 1 : (cnt > MaxPoints) ? MaxPoints : cnt;
      pts = 0;
      while (pts < total) begin
         fb = 8'($urandom_range(0, 255));
         fb[FlagRepeatBit] = ($urandom_range(0, 3) == 0);
         body.push_back(fb);
         point_flags.push_back(fb);
         pts++;
         if (fb[FlagRepeatBit]) begin
            room = total - pts;
            if ($urandom_range(0, 4) == 0)
               rep = $urandom_range(0, 1) ? 255 : room + $urandom_range(1, 3);
            else
               rep = $urandom_range(0, room);
            body.push_back(8'(rep));
            repeat ((rep > room) ? room : rep) begin
               point_flags.push_back(fb);
               pts++;
            end
         end
      end
      for (int ax = 0; ax < 2; ax++) begin
         foreach (point_flags[i]) begin
            if (point_flags[i][1 + ax]) begin
               body.push_back(8'($urandom_range(0, 255)));
            end else if (!point_flags[i][4 + ax]) begin
               body.push_back(8'($urandom_range(0, 255)));
               body.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      // some glyphs are abandoned part way, some trailed by stray bytes
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size() - 1) : body.size();
      push_begin(6'(cnt));
      for (int i = 0; i < keep; i++) push_data(body[i]);
      if (keep == body.size() && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) push_data(8'($urandom_range(0, 255)));
   endtask

   // request side: random gaps, a calm stretch with none
   task automatic feed_decoder();
      int gap;
      foreach (stim[i]) begin
         gap = (i >= 70 && i < 100) ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_item  <= stim[i];
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off, a calm stretch
   initial begin : result_sink
      int hold;
      int taken;
      taken = 0;
      wait (!reset);
      forever begin
         if (taken == 40) hold = 250;
         else if (taken >= 200 && taken < 260) hold = 0;
         else hold = $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_item);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_item);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, StuckLimit);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : main_flow
      sb = new();

      // directed glyphs
      push_data(8'hAA);          // byte while idle
      push_begin(6'd0);          // zero count taken as one point
      push_data(8'h37);          // on, both short positive
      push_data(8'hFF);
      push_data(8'hFF);
      push_begin(6'd63);         // capped at capacity
      push_data(8'h39);          // repeat, both long same
      push_data(8'hFF);          // overrun clipped, full burst of both axes
      push_begin(6'd2);
      push_data(8'h00);          // long deltas
      push_data(8'h06);          // short negative deltas
      push_data(8'h80);
      push_data(8'h00);          // most negative x
      push_data(8'h01);          // wraps to most positive
      push_data(8'h7F);
      push_data(8'hFF);
      push_data(8'h80);
      push_data(8'h55);          // byte after the final y
      push_begin(6'd3);
      push_data(8'h39);
      push_data(8'h02);          // run fills the glyph exactly
      push_begin(6'd1);
      push_data(8'h18);          // repeat on the last point
      push_data(8'h00);
      push_data(8'h12);
      push_data(8'h34);
      push_begin(6'd40);
      push_data(8'hC0);          // upper flag bits ignored, glyph abandoned

      // random glyphs trimmed to size, closed by a begin so no burst is left
      while (stim.size() < StimItems) add_glyph();
      while (stim.size() > StimItems) void'(stim.pop_back());
      push_begin(6'($urandom_range(0, 63)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      feed_decoder();
      while (sb.coords_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("%0d items over %0d glyph starts, %0d results checked",
               sb.items, sb.begins, sb.results);
      $display("%0d clipped repeat runs, %0d mismatches", sb.clips, sb.errors);
      if (sb.errors == 0 && sb.coords_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
